// File: src/stp_bridge_root_and_port_roles_defines.svh
// assertion macros shared by the checker of the spanning-tree bridge engine
// no dependencies; taken in by `include where assertions are written
`ifndef STP_BRIDGE_ROOT_AND_PORT_ROLES_DEFINES_SVH
`define STP_BRIDGE_ROOT_AND_PORT_ROLES_DEFINES_SVH

// same-cycle implication, off during reset
`define STP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define STP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/stp_pkg.sv
// shared types, codes and constants of the spanning-tree bridge engine
// no dependencies; imported by every module of the block
package stp_pkg;

    localparam int MAC_W        = 48;
    localparam int IN_COST_W    = 16;
    localparam int PORT_W       = 3;
    localparam int ROLES_W      = 16;
    localparam int PCOUNT_W     = 4;
    localparam int REPORT_PORTS = 8;

    // defaults of the top-level parameters
    localparam int PORTS_DEF       = 8;
    localparam int COST_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    // register port
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 64;
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_OWN_MAC    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_STP_ENABLE = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_PORT_COUNT = 2'd2;

    localparam logic [MAC_W-1:0]    OWN_MAC_RST    = '0;
    localparam logic                STP_ENABLE_RST = 1'b1;
    localparam logic [PCOUNT_W-1:0] PORT_COUNT_RST = 4'd8;

    // item and result codes
    localparam logic FUNC_BPDU   = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;
    localparam logic KIND_BPDU   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic [1:0] ROLE_DESIGNATED = 2'd0;
    localparam logic [1:0] ROLE_ROOT       = 2'd1;
    localparam logic [1:0] ROLE_BLOCKED    = 2'd2;

    typedef struct packed {
        logic [MAC_W-1:0]    own_mac;
        logic                stp_enable;
        logic [PCOUNT_W-1:0] port_count;
    } stp_cfg_t;

    typedef struct packed {
        logic                 func;
        logic [PORT_W-1:0]    in_port;
        logic [MAC_W-1:0]     bpdu_root;
        logic [IN_COST_W-1:0] bpdu_cost;
        logic [MAC_W-1:0]     sender_mac;
        logic [IN_COST_W-1:0] link_cost;
    } stp_item_t;

endpackage

// File: src/stp_queue.sv
// short command queue between the front classifier and the back engine
// depends on stp_pkg for the queued item type
module stp_queue
    import stp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  stp_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      empty,
    output stp_item_t head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    stp_item_t          slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign empty     = (cnt_reg == '0);
    assign head_item = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: src/stp_front.sv
// front classifier: takes input transfers, drops bpdus on ports out of use
// depends on stp_pkg for the config and item types
module stp_front
    import stp_pkg::*;
#(
    parameter int PORTS = PORTS_DEF
)
(
    input  stp_cfg_t             cfg,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic                 func,
    input  logic [PORT_W-1:0]    in_port,
    input  logic [MAC_W-1:0]     bpdu_root,
    input  logic [IN_COST_W-1:0] bpdu_cost,
    input  logic [MAC_W-1:0]     sender_mac,
    input  logic [IN_COST_W-1:0] link_cost,
    input  logic                 q_full,
    output logic                 q_push,
    output stp_item_t            q_item
);

    logic accept;
    logic port_in_use;

    // port must sit below both the configured count and the built-in port count
    assign port_in_use = ({1'b0, in_port} < cfg.port_count)
                      && (32'(in_port) < 32'(PORTS));

    assign item_stall = q_full;
    assign accept     = item_valid && !q_full;
    assign q_push     = accept && ((func == FUNC_TICK) || port_in_use);

    always_comb
    begin
        q_item.func       = func;
        q_item.in_port    = in_port;
        q_item.bpdu_root  = bpdu_root;
        q_item.bpdu_cost  = bpdu_cost;
        q_item.sender_mac = sender_mac;
        q_item.link_cost  = link_cost;
    end

endmodule

// File: src/stp_back.sv
// back engine: root election, neighbor memory, port role walk, result register
// depends on stp_pkg for codes, config and item types
module stp_back
    import stp_pkg::*;
#(
    parameter int PORTS     = PORTS_DEF,
    parameter int COST_BITS = COST_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  stp_cfg_t             cfg,
    input  logic                 q_empty,
    input  stp_item_t            q_item,
    output logic                 q_pop,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic                 kind,
    output logic [MAC_W-1:0]     out_root_id,
    output logic [IN_COST_W-1:0] out_cost,
    output logic [MAC_W-1:0]     out_sender,
    output logic [ROLES_W-1:0]   port_roles,
    output logic                 last
);

    localparam int IDX_W = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam int CMP_W = (IDX_W > PCOUNT_W) ? IDX_W : PCOUNT_W;
    localparam int SUM_W = ((COST_BITS > IN_COST_W) ? COST_BITS : IN_COST_W) + 1;
    localparam logic [SUM_W-1:0] COST_MAX_W = SUM_W'((64'd1 << COST_BITS) - 64'd1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_BPDU   = 3'd1;
    localparam logic [2:0] S_TICK   = 3'd2;
    localparam logic [2:0] S_WALK   = 3'd3;
    localparam logic [2:0] S_REPORT = 3'd4;

    function automatic logic [COST_BITS-1:0] sat_cost(input logic [SUM_W-1:0] v);
        logic [SUM_W-1:0] s;
        s = (v > COST_MAX_W) ? COST_MAX_W : v;
        return COST_BITS'(s);
    endfunction

    // neighbor memory, no reset
    logic [COST_BITS-1:0] ncost_mem [PORTS];
    logic [MAC_W-1:0]     nmac_mem  [PORTS];
    logic [COST_BITS-1:0] rd_cost_reg;
    logic [MAC_W-1:0]     rd_mac_reg;

    logic [2:0]           state_reg, state_next;
    stp_item_t            cur_reg, cur_next;
    logic                 self_root_reg, self_root_next;
    logic [MAC_W-1:0]     root_id_reg, root_id_next;
    logic [COST_BITS-1:0] root_cost_reg, root_cost_next;
    logic [PORT_W-1:0]    up_port_reg, up_port_next;
    logic                 rport_vld_reg, rport_vld_next;
    logic [PORTS-1:0]     nvalid_reg, nvalid_next;
    logic [CNT_W-1:0]     rd_cnt_reg, rd_cnt_next;
    logic [IDX_W-1:0]     eval_idx_reg, eval_idx_next;
    logic                 eval_vld_reg, eval_vld_next;
    logic [ROLES_W-1:0]   roles_reg, roles_next;

    logic                 res_vld_reg, res_vld_next;
    logic                 kind_reg, kind_next;
    logic [MAC_W-1:0]     root_out_reg, root_out_next;
    logic [IN_COST_W-1:0] cost_out_reg, cost_out_next;
    logic [MAC_W-1:0]     sender_reg, sender_next;
    logic [ROLES_W-1:0]   roles_out_reg, roles_out_next;
    logic                 last_reg, last_next;

    logic                 out_free;
    logic                 own_root;
    logic [MAC_W-1:0]     cur_root;
    logic [COST_BITS-1:0] bcost_sat, lcost_sat, path_cost;
    logic                 adopt;
    logic                 mem_we;
    logic [IDX_W-1:0]     wr_idx;
    logic                 rd_en;
    logic [CMP_W-1:0]     eval_port;
    logic [1:0]           role;

    assign out_free  = !res_vld_reg || !result_stall;
    assign own_root  = self_root_reg || (root_id_reg == cfg.own_mac);
    assign cur_root  = own_root ? cfg.own_mac : root_id_reg;
    assign bcost_sat = sat_cost(SUM_W'(cur_reg.bpdu_cost));
    assign lcost_sat = sat_cost(SUM_W'(cur_reg.link_cost));
    assign path_cost = sat_cost(SUM_W'(bcost_sat) + SUM_W'(lcost_sat));
    assign adopt     = (cur_reg.bpdu_root < cur_root)
                    || ((cur_reg.bpdu_root == cur_root) && (path_cost < root_cost_reg));
    assign wr_idx    = IDX_W'(cur_reg.in_port);
    assign rd_en     = (state_reg == S_WALK) && (rd_cnt_reg < CNT_W'(PORTS));
    assign eval_port = CMP_W'(eval_idx_reg);

    // role of the port in the evaluate stage
    always_comb
    begin
        if ((eval_port >= CMP_W'(cfg.port_count)) || !cfg.stp_enable)
        begin
            role = ROLE_DESIGNATED;
        end
        else if (rport_vld_reg && (eval_port == CMP_W'(up_port_reg)))
        begin
            role = ROLE_ROOT;
        end
        else if (!nvalid_reg[eval_idx_reg])
        begin
            role = ROLE_DESIGNATED;
        end
        else if (root_cost_reg < rd_cost_reg)
        begin
            role = ROLE_DESIGNATED;
        end
        else if (root_cost_reg > rd_cost_reg)
        begin
            role = ROLE_BLOCKED;
        end
        else
        begin
            role = (cfg.own_mac < rd_mac_reg) ? ROLE_DESIGNATED : ROLE_BLOCKED;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        self_root_next = self_root_reg;
        root_id_next   = root_id_reg;
        root_cost_next = root_cost_reg;
        up_port_next   = up_port_reg;
        rport_vld_next = rport_vld_reg;
        nvalid_next    = nvalid_reg;
        rd_cnt_next    = rd_cnt_reg;
        eval_idx_next  = eval_idx_reg;
        eval_vld_next  = eval_vld_reg;
        roles_next     = roles_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;

        res_vld_next   = res_vld_reg && result_stall;
        kind_next      = kind_reg;
        root_out_next  = root_out_reg;
        cost_out_next  = cost_out_reg;
        sender_next    = sender_reg;
        roles_out_next = roles_out_reg;
        last_next      = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop         = 1'b1;
                    cur_next      = q_item;
                    rd_cnt_next   = '0;
                    eval_vld_next = 1'b0;
                    roles_next    = '0;
                    state_next    = (q_item.func == FUNC_TICK) ? S_TICK : S_BPDU;
                end
            end
            S_BPDU:
            begin
                if (!adopt || out_free)
                begin
                    mem_we                 = 1'b1;
                    nvalid_next[wr_idx]    = 1'b1;
                    state_next             = S_IDLE;
                end
                if (adopt && out_free)
                begin
                    self_root_next = 1'b0;
                    root_id_next   = cur_reg.bpdu_root;
                    root_cost_next = path_cost;
                    up_port_next   = cur_reg.in_port;
                    rport_vld_next = 1'b1;
                    res_vld_next   = 1'b1;
                    kind_next      = KIND_BPDU;
                    root_out_next  = cur_reg.bpdu_root;
                    cost_out_next  = IN_COST_W'(path_cost);
                    sender_next    = cfg.own_mac;
                    roles_out_next = '0;
                    last_next      = 1'b1;
                end
            end
            S_TICK:
            begin
                if (cfg.stp_enable && own_root)
                begin
                    if (out_free)
                    begin
                        res_vld_next   = 1'b1;
                        kind_next      = KIND_BPDU;
                        root_out_next  = cfg.own_mac;
                        cost_out_next  = IN_COST_W'(root_cost_reg);
                        sender_next    = cfg.own_mac;
                        roles_out_next = '0;
                        last_next      = 1'b0;
                        state_next     = S_WALK;
                    end
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                // read stage
                if (rd_en)
                begin
                    rd_cnt_next   = rd_cnt_reg + 1'b1;
                    eval_idx_next = rd_cnt_reg[IDX_W-1:0];
                    eval_vld_next = 1'b1;
                end
                else
                begin
                    eval_vld_next = 1'b0;
                end
                // evaluate stage
                if (eval_vld_reg)
                begin
                    for (int k = 0; k < REPORT_PORTS; k++)
                    begin
                        if (eval_port == CMP_W'(k))
                        begin
                            roles_next[2*k +: 2] = role;
                        end
                    end
                    if (eval_idx_reg == IDX_W'(PORTS - 1))
                    begin
                        state_next = S_REPORT;
                    end
                end
            end
            S_REPORT:
            begin
                if (out_free)
                begin
                    res_vld_next   = 1'b1;
                    kind_next      = KIND_REPORT;
                    root_out_next  = '0;
                    cost_out_next  = '0;
                    sender_next    = '0;
                    roles_out_next = roles_reg;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            self_root_reg <= 1'b1;
            root_id_reg   <= '0;
            root_cost_reg <= '0;
            up_port_reg   <= '0;
            rport_vld_reg <= 1'b0;
            nvalid_reg    <= '0;
            rd_cnt_reg    <= '0;
            eval_idx_reg  <= '0;
            eval_vld_reg  <= 1'b0;
            roles_reg     <= '0;
            res_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            self_root_reg <= self_root_next;
            root_id_reg   <= root_id_next;
            root_cost_reg <= root_cost_next;
            up_port_reg   <= up_port_next;
            rport_vld_reg <= rport_vld_next;
            nvalid_reg    <= nvalid_next;
            rd_cnt_reg    <= rd_cnt_next;
            eval_idx_reg  <= eval_idx_next;
            eval_vld_reg  <= eval_vld_next;
            roles_reg     <= roles_next;
            res_vld_reg   <= res_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        kind_reg      <= kind_next;
        root_out_reg  <= root_out_next;
        cost_out_reg  <= cost_out_next;
        sender_reg    <= sender_next;
        roles_out_reg <= roles_out_next;
        last_reg      <= last_next;
    end

    // neighbor memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ncost_mem[wr_idx] <= bcost_sat;
            nmac_mem[wr_idx]  <= cur_reg.sender_mac;
        end
        if (rd_en)
        begin
            rd_cost_reg <= ncost_mem[rd_cnt_reg[IDX_W-1:0]];
            rd_mac_reg  <= nmac_mem[rd_cnt_reg[IDX_W-1:0]];
        end
    end

    assign result_valid = res_vld_reg;
    assign kind         = kind_reg;
    assign out_root_id  = root_out_reg;
    assign out_cost     = cost_out_reg;
    assign out_sender   = sender_reg;
    assign port_roles   = roles_out_reg;
    assign last         = last_reg;

endmodule

// File: src/stp_bridge_root_and_port_roles.sv
// top level of the spanning-tree bridge engine: register port, front, queue, back
// depends on stp_pkg, stp_front, stp_queue and stp_back
//
// usage
// - register port (apb style, 64-bit data): own_mac at 0x00, stp_enable at 0x08,
//   port_count at 0x10; write only while the block is idle
// - item channel: item_valid / item_stall; func 0 carries a received bpdu,
//   func 1 is a tick; a bpdu on a port out of use is taken and dropped
// - result channel: result_valid / result_stall; kind 0 is a bpdu to send,
//   kind 1 a port role report; last marks the final result of an item
// - in the back engine a bpdu passes through the bpdu state; a tick passes the tick
//   state, then the role walk that reads one port a cycle from the neighbor
//   memory, then the report state
// - the queue between front and back holds QUEUE_DEPTH items, so new transfers
//   are taken while a result still waits in the output register
// - a stalled result holds; the engine waits at its next result and the queue fills
// - reset: own root with cost 0, no root port, no neighbor heard, stp on,
//   all 8 ports in use; no clearing pass is needed
module stp_bridge_root_and_port_roles
    import stp_pkg::*;
#(
    parameter int PORTS       = PORTS_DEF,
    parameter int COST_BITS   = COST_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // register port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready,
    // item channel
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic                 func,
    input  logic [PORT_W-1:0]    in_port,
    input  logic [MAC_W-1:0]     bpdu_root,
    input  logic [IN_COST_W-1:0] bpdu_cost,
    input  logic [MAC_W-1:0]     sender_mac,
    input  logic [IN_COST_W-1:0] link_cost,
    // result channel
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic                 kind,
    output logic [MAC_W-1:0]     out_root_id,
    output logic [IN_COST_W-1:0] out_cost,
    output logic [MAC_W-1:0]     out_sender,
    output logic [ROLES_W-1:0]   port_roles,
    output logic                 last
);

    logic [MAC_W-1:0]     own_mac_reg, own_mac_next;
    logic                 stp_en_reg, stp_en_next;
    logic [PCOUNT_W-1:0]  pcount_reg, pcount_next;
    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] reg_idx;
    stp_cfg_t             cfg;

    logic                 q_push, q_full, q_pop, q_empty;
    stp_item_t            push_item, head_item;

    // register decode: one register every 8 bytes, low address bits ignored
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:3];

    always_comb
    begin
        own_mac_next = own_mac_reg;
        stp_en_next  = stp_en_reg;
        pcount_next  = pcount_reg;
        if (cfg_wr)
        begin
            case (reg_idx)
                REG_OWN_MAC:    own_mac_next = pwdata[MAC_W-1:0];
                REG_STP_ENABLE: stp_en_next  = pwdata[0];
                REG_PORT_COUNT: pcount_next  = pwdata[PCOUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_OWN_MAC:    prdata = DATA_W'(own_mac_reg);
            REG_STP_ENABLE: prdata = DATA_W'(stp_en_reg);
            REG_PORT_COUNT: prdata = DATA_W'(pcount_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg <= OWN_MAC_RST;
            stp_en_reg  <= STP_ENABLE_RST;
            pcount_reg  <= PORT_COUNT_RST;
        end
        else
        begin
            own_mac_reg <= own_mac_next;
            stp_en_reg  <= stp_en_next;
            pcount_reg  <= pcount_next;
        end
    end

    assign cfg.own_mac    = own_mac_reg;
    assign cfg.stp_enable = stp_en_reg;
    assign cfg.port_count = pcount_reg;

    // front: accept and classify
    stp_front #(
        .PORTS (PORTS)
    ) u_front (
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .func       (func),
        .in_port    (in_port),
        .bpdu_root  (bpdu_root),
        .bpdu_cost  (bpdu_cost),
        .sender_mac (sender_mac),
        .link_cost  (link_cost),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (push_item)
    );

    // decoupling queue
    stp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head_item (head_item)
    );

    // back: election, role walk, result register
    stp_back #(
        .PORTS     (PORTS),
        .COST_BITS (COST_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_empty      (q_empty),
        .q_item       (head_item),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kind         (kind),
        .out_root_id  (out_root_id),
        .out_cost     (out_cost),
        .out_sender   (out_sender),
        .port_roles   (port_roles),
        .last         (last)
    );

endmodule

// File: src/stp_checker.sv
// port-level checker of the spanning-tree bridge engine, bound to the top level
// depends on stp_pkg and the assertion macros header
`include "stp_bridge_root_and_port_roles_defines.svh"

module stp_checker
    import stp_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 result_valid,
    input logic                 result_stall,
    input logic                 kind,
    input logic [MAC_W-1:0]     out_root_id,
    input logic [IN_COST_W-1:0] out_cost,
    input logic [MAC_W-1:0]     out_sender,
    input logic [ROLES_W-1:0]   port_roles,
    input logic                 last
);

    `STP_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(kind) && $stable(out_root_id) && $stable(port_roles) && $stable(last), "stalled result changed")
    `STP_ASSERT_SAME(a_report_blank, clk, rst_n, result_valid && (kind == KIND_REPORT), (out_root_id == '0) && (out_cost == '0) && (out_sender == '0), "role report carries bpdu fields")
    `STP_ASSERT_SAME(a_bpdu_no_roles, clk, rst_n, result_valid && (kind == KIND_BPDU), port_roles == '0, "bpdu result carries port roles")
    `STP_ASSERT_SAME(a_report_last, clk, rst_n, result_valid && (kind == KIND_REPORT), last, "role report not marked last")

endmodule

bind stp_bridge_root_and_port_roles stp_checker u_checker (.*);
